// File: hw/rtl/pglm_pkg.sv
// shared types and constants of the periodic grid local maximum block
`default_nettype none

package pglm_pkg;

    localparam int SIZE_W = 7;
    localparam int IDX_W  = 15;
    localparam int CLR_W  = 32;
    localparam int VOL_W  = 3 * SIZE_W;
    localparam int DATA_W = CLR_W + 1;
    localparam int CFG_W  = 2;

    localparam logic [CFG_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd32;

    typedef struct packed {
        logic              start;
        logic [IDX_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [IDX_W-1:0]  quotient;
        logic [SIZE_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/pglm_ram.sv
// simple dual-port voxel store, one write and one registered read per cycle
`default_nettype none

module pglm_ram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned WIDTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/pglm_div.sv
// restoring divider, one quotient bit per cycle, splits the linear index into axes
`default_nettype none

module pglm_div
    import pglm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam logic [3:0] LAST_STEP = 4'(IDX_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [IDX_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;

    logic [SIZE_W:0]   w_shift;
    logic [SIZE_W:0]   w_diff;
    logic              w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[IDX_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the narrow register
            r_rem <= w_ge ? w_diff[SIZE_W-1:0] : w_shift[SIZE_W-1:0];
            r_quo <= {r_quo[IDX_W-2:0], w_ge};
        end
    end

    always_comb begin
        o_rsp.busy      = r_busy;
        o_rsp.done      = r_done;
        o_rsp.quotient  = r_quo;
        o_rsp.remainder = r_rem;
    end

endmodule

`default_nettype wire

// File: hw/rtl/periodic_grid_local_maximum.sv
// Periodic 3D voxel grid with a 26-neighbour local maximum query.
// Input channel (i_in_valid / o_in_ready) carries one item per beat: a write
// stores clearance and region mark of one voxel, a query tests one voxel.
// Output channel (o_out_valid / i_out_ready) returns exactly one beat per item:
// o_index_error when the index lies outside size_x*size_y*size_z or that
// volume exceeds MAX_VOXELS, else o_is_local_max for a query (0 on a write).
// Sizes are set through i_cfg_we / i_cfg_index / i_cfg_data; the user must
// write them only while idle, the block does not enforce this. One item is
// handled at a time. A write or a flagged item goes from S_CHECK to S_DONE.
// A query runs two 15-step serial divisions that split the index into x, y and
// z, six products of row and plane offsets on one shared multiplier, and 28
// memory reads, one per cycle: the voxel, then all 27 wrapped positions.
// The output register holds a result until it is taken; the next item is
// accepted meanwhile and its result waits in the final state if the receiver
// still stalls. Reset sets all sizes to 32 and empties the pipeline; the
// voxel store is not cleared, so the whole grid must be written before queries.
`default_nettype none

module periodic_grid_local_maximum
    import pglm_pkg::*;
#(
    parameter int unsigned MAX_VOXELS = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_func,
    input  wire logic [IDX_W-1:0]         i_voxel_index,
    input  wire logic signed [CLR_W-1:0]  i_clearance_value,
    input  wire logic                     i_in_region,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_is_local_max,
    output logic                          o_index_error,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_W-1:0]         i_cfg_index,
    input  wire logic [SIZE_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_VOXELS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VOL1,
        S_VOL2,
        S_CHECK,
        S_DIV1,
        S_DIV2,
        S_WRAP,
        S_MUL,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    logic [SIZE_W-1:0]   r_size_x;
    logic [SIZE_W-1:0]   r_size_y;
    logic [SIZE_W-1:0]   r_size_z;

    logic                r_func;
    logic [IDX_W-1:0]    r_idx;
    logic [CLR_W-1:0]    r_clr;
    logic                r_reg;

    logic [2*SIZE_W-1:0] r_sxy;
    logic [VOL_W-1:0]    r_vol;

    logic [SIZE_W-1:0]   r_x0;
    logic [SIZE_W-1:0]   r_y0;
    logic [SIZE_W-1:0]   r_z0;
    logic [SIZE_W-1:0]   r_xc [3];
    logic [SIZE_W-1:0]   r_yc [3];
    logic [SIZE_W-1:0]   r_zc [3];
    logic [ADDR_W-1:0]   r_yoff [3];
    logic [ADDR_W-1:0]   r_zoff [3];
    logic [2:0]          r_pidx;

    logic                r_first;
    logic [1:0]          r_cx;
    logic [1:0]          r_cy;
    logic [1:0]          r_cz;
    logic                r_rd_vld;
    logic                r_rd_self;
    logic [CLR_W-1:0]    r_self_clr;
    logic                r_self_reg;
    logic                r_fail;

    logic                r_res_lm;
    logic                r_res_err;
    logic                r_out_valid;
    logic                r_out_lm;
    logic                r_out_err;

    logic                w_err;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_self_addr;
    logic [ADDR_W-1:0]   w_raddr;
    logic [DATA_W-1:0]   w_rdata;
    logic                w_rd_region;
    logic [CLR_W-1:0]    w_rd_clr;
    logic                w_hit;
    logic [2*SIZE_W-1:0] w_op_a;
    logic [SIZE_W-1:0]   w_op_b;
    logic [VOL_W-1:0]    w_prod;
    logic                w_scan_last;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    function automatic logic [SIZE_W-1:0] f_dec(
        input logic [SIZE_W-1:0] pos,
        input logic [SIZE_W-1:0] n
    );
        return (pos == '0) ? n - 7'd1 : pos - 7'd1;
    endfunction

    function automatic logic [SIZE_W-1:0] f_inc(
        input logic [SIZE_W-1:0] pos,
        input logic [SIZE_W-1:0] n
    );
        logic [SIZE_W:0] nxt;
        nxt = {1'b0, pos} + 8'd1;
        return (nxt >= {1'b0, n}) ? '0 : nxt[SIZE_W-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_err       = (r_vol > VOL_W'(MAX_VOXELS)) || (VOL_W'(r_idx) >= r_vol);
        w_ram_we    = (r_state == S_CHECK) && !w_err && (r_func == FUNC_WRITE);
        w_self_addr = ADDR_W'(r_idx);
        w_raddr     = r_first ? w_self_addr
                              : ADDR_W'(r_xc[r_cx]) + r_yoff[r_cy] + r_zoff[r_cz];
        w_rd_region = w_rdata[DATA_W-1];
        w_rd_clr    = w_rdata[CLR_W-1:0];
        w_hit       = r_rd_vld && !r_rd_self && w_rd_region
                      && ($signed(w_rd_clr) > $signed(r_self_clr));
        w_scan_last = !r_first && (r_cx == 2'd2) && (r_cy == 2'd2) && (r_cz == 2'd2);
    end

    // shared multiplier: x size times y coordinates, then plane size times z
    always_comb begin
        w_op_a = (r_pidx < 3'd3) ? {{SIZE_W{1'b0}}, r_size_x} : r_sxy;
        unique case (r_pidx)
            3'd0:    w_op_b = r_yc[0];
            3'd1:    w_op_b = r_yc[1];
            3'd2:    w_op_b = r_yc[2];
            3'd3:    w_op_b = r_zc[0];
            3'd4:    w_op_b = r_zc[1];
            default: w_op_b = r_zc[2];
        endcase
        w_prod = w_op_a * w_op_b;
    end

    always_comb begin
        w_div_req.start    = ((r_state == S_CHECK) && !w_err && (r_func == FUNC_QUERY))
                             || ((r_state == S_DIV1) && w_div_rsp.done);
        w_div_req.dividend = (r_state == S_CHECK) ? r_idx : w_div_rsp.quotient;
        w_div_req.divisor  = (r_state == S_CHECK) ? r_size_x : r_size_y;
    end

    pglm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    pglm_ram #(
        .DEPTH (MAX_VOXELS),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_self_addr),
        .i_wdata ({r_reg, r_clr}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer, scan counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pidx      <= '0;
            r_first     <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_self   <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == S_SCAN);
            r_rd_self <= r_first;
            if (w_hit) begin
                r_fail <= 1'b1;
            end

            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_VOL1;
                    end
                end
                S_VOL1: r_state <= S_VOL2;
                S_VOL2: r_state <= S_CHECK;
                S_CHECK: begin
                    if (w_err || (r_func == FUNC_WRITE)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_pidx  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pidx <= r_pidx + 3'd1;
                    if (r_pidx == 3'd5) begin
                        r_first <= 1'b1;
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_cz    <= '0;
                        r_fail  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    if (w_scan_last) begin
                        r_state <= S_DRAIN;
                    end else if (!r_first) begin
                        if (r_cx == 2'd2) begin
                            r_cx <= '0;
                            if (r_cy == 2'd2) begin
                                r_cy <= '0;
                                r_cz <= r_cz + 2'd1;
                            end else begin
                                r_cy <= r_cy + 2'd1;
                            end
                        end else begin
                            r_cx <= r_cx + 2'd1;
                        end
                    end
                end
                S_DRAIN: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_func <= i_func;
            r_idx  <= i_voxel_index;
            r_clr  <= i_clearance_value;
            r_reg  <= i_in_region;
        end
        if (r_state == S_VOL1) begin
            r_sxy <= r_size_x * r_size_y;
        end
        if (r_state == S_VOL2) begin
            r_vol <= r_sxy * r_size_z;
        end
        if (r_state == S_CHECK) begin
            r_res_err <= w_err;
            r_res_lm  <= 1'b0;
        end
        if ((r_state == S_DIV1) && w_div_rsp.done) begin
            r_x0 <= w_div_rsp.remainder;
        end
        if ((r_state == S_DIV2) && w_div_rsp.done) begin
            r_y0 <= w_div_rsp.remainder;
            r_z0 <= w_div_rsp.quotient[SIZE_W-1:0];
        end
        if (r_state == S_WRAP) begin
            r_xc[0] <= f_dec(r_x0, r_size_x);
            r_xc[1] <= r_x0;
            r_xc[2] <= f_inc(r_x0, r_size_x);
            r_yc[0] <= f_dec(r_y0, r_size_y);
            r_yc[1] <= r_y0;
            r_yc[2] <= f_inc(r_y0, r_size_y);
            r_zc[0] <= f_dec(r_z0, r_size_z);
            r_zc[1] <= r_z0;
            r_zc[2] <= f_inc(r_z0, r_size_z);
        end
        if (r_state == S_MUL) begin
            unique case (r_pidx)
                3'd0:    r_yoff[0] <= ADDR_W'(w_prod);
                3'd1:    r_yoff[1] <= ADDR_W'(w_prod);
                3'd2:    r_yoff[2] <= ADDR_W'(w_prod);
                3'd3:    r_zoff[0] <= ADDR_W'(w_prod);
                3'd4:    r_zoff[1] <= ADDR_W'(w_prod);
                default: r_zoff[2] <= ADDR_W'(w_prod);
            endcase
        end
        if (r_rd_vld && r_rd_self) begin
            r_self_clr <= w_rd_clr;
            r_self_reg <= w_rd_region;
        end
        if (r_state == S_DRAIN) begin
            r_res_lm <= r_self_reg && !(r_fail || w_hit);
        end
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out_lm  <= r_res_lm;
            r_out_err <= r_res_err;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_is_local_max = r_out_lm;
    assign o_index_error  = r_out_err;

`ifndef SYNTHESIS
    a_err_no_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_index_error) |-> !o_is_local_max)
        else $error("flagged beat reports a local maximum");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cx != 2'd3 && r_cy != 2'd3 && r_cz != 2'd3))
        else $error("neighbour counter out of range");

    a_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("read data arrives outside the scan");
`endif

endmodule

`default_nettype wire
